FILE: rtl/core/sbba_pkg.sv
// Shared types, constants and control structs for the sectioned bitmap block allocator.
package sbba_pkg;

  // Field and register widths
  localparam int BLK_W  = 13;            // block number
  localparam int BPS_W  = 11;            // blocks_per_section register
  localparam int SEC_W  = 4;             // section_count register
  localparam int STAT_W = 2;
  localparam int GOT_W  = BPS_W + SEC_W; // block position before truncation
  localparam int NB_W   = BPS_W - 2;     // bytes per section, up to 256
  localparam int J_W    = BPS_W - 3;     // byte index inside a section
  localparam int CAND_W = SEC_W + 1;     // next-section candidate

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = BPS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BPS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NSEC = 8'd1;
  localparam logic [BPS_W-1:0] BPS_RST  = 11'd1024;
  localparam logic [SEC_W-1:0] NSEC_RST = 4'd8;

  // Parameter defaults
  localparam int MAX_BPS_DEF = 1024;
  localparam int MAX_SEC_DEF = 8;

  // Request and status codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [BLK_W-1:0] block_number;
  } in_word_t;

  typedef struct packed {
    logic [BLK_W-1:0]  granted_block;
    logic [STAT_W-1:0] status;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;        // write zero at clear pointer, advance
    logic capture;    // latch accepted word
    logic set_range;  // answer out of range
    logic div_init;   // start section search for the block
    logic div_step;   // subtract one section
    logic hint_upd;   // read-modify-write the hint bit
    logic scan_init;  // start scanning the hint's section
    logic scan;       // one byte of the section scan
    logic next_sec;   // move to the next section
    logic set_full;   // answer no free block
    logic out_load;   // push result into output register
  } sbba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic div_done;
    logic hint_taken;
    logic scan_hit;
    logic sec_done;
    logic no_sec;
  } sbba_sts_t;

endpackage

FILE: rtl/core/sectioned_bitmap_block_allocator_top.sv
// Top level of the sectioned bitmap block allocator: config registers, output register, units.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+-----------------------------------
//   in_     | input     | in_valid / in_stall | in_word_t  (req_type, block_number)
//   out_    | output    | out_valid/out_stall | out_word_t (granted_block, status)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word is worked on at a time. A free, or an allocate whose hint is free, needs
// up to section_count - 1 section steps to locate the block's section. A full scan
// reads the bytes of each section in turn, bound by the single read port of the
// bitmap memory. After reset a clearing pass writes every bitmap byte to zero, one
// byte per cycle over SECTION_BYTES * MAX_SECTIONS bytes (1024 by default); in_stall
// stays high then. A finished word waits in the output register; the next input word
// is accepted while it waits, and the following result is held until the output drains.
module sectioned_bitmap_block_allocator_top import sbba_pkg::*; #(
  parameter int MAX_BLOCKS_PER_SECTION = MAX_BPS_DEF,
  parameter int MAX_SECTIONS           = MAX_SEC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BPS_W-1:0]  cfg_bps_r;
  logic [SEC_W-1:0]  cfg_nsec_r;
  logic [BPS_W-1:0]  bps_eff;
  logic [SEC_W-1:0]  nsec_eff;
  logic              out_valid_r;
  out_word_t         out_word_r;
  logic              out_free;
  sbba_cmd_t         cmd;
  sbba_sts_t         sts;
  logic [BLK_W-1:0]  res_block;
  logic [STAT_W-1:0] res_status;

  // Config writes must land only while idle; the block does not enforce this and always takes them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bps_r  <= BPS_RST;
      cfg_nsec_r <= NSEC_RST;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to unknown indexes
      if (cfg_index == CFG_BPS)  cfg_bps_r  <= cfg_data;
      if (cfg_index == CFG_NSEC) cfg_nsec_r <= cfg_data[SEC_W-1:0];
    end
  end

  // Clamp register values into the legal range; zero counts as one.
  always_comb begin
    if (cfg_bps_r == '0) begin
      bps_eff = BPS_W'(1);
    end else if (32'(cfg_bps_r) > MAX_BLOCKS_PER_SECTION) begin
      bps_eff = BPS_W'(MAX_BLOCKS_PER_SECTION);
    end else begin
      bps_eff = cfg_bps_r;
    end
    if (cfg_nsec_r == '0) begin
      nsec_eff = SEC_W'(1);
    end else if (32'(cfg_nsec_r) > MAX_SECTIONS) begin
      nsec_eff = SEC_W'(MAX_SECTIONS);
    end else begin
      nsec_eff = cfg_nsec_r;
    end
  end

  // Output register: load when empty or draining, clear once taken.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.granted_block <= res_block;
      out_word_r.status        <= res_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  sbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sbba_dp #(
    .MAX_BLOCKS_PER_SECTION (MAX_BLOCKS_PER_SECTION),
    .MAX_SECTIONS           (MAX_SECTIONS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .bps        (bps_eff),
    .nsec       (nsec_eff),
    .cmd        (cmd),
    .sts        (sts),
    .res_block  (res_block),
    .res_status (res_status)
  );

  // A result never overwrites one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting word");

  // A failed request reports block zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.status == ST_DONE || out_word_r.granted_block == '0))
    else $error("failed request with nonzero block");

  // No two result loads back to back.
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !cmd.out_load)
    else $error("double result load");

  // Once a word is taken the block is busy until its result is loaded.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !cmd.out_load))
    else $error("input accepted while busy");

endmodule

FILE: rtl/core/sbba_dp.sv
// Datapath: bitmap memory, section search, byte scan and result registers.
module sbba_dp import sbba_pkg::*; #(
  parameter int MAX_BLOCKS_PER_SECTION = MAX_BPS_DEF,
  parameter int MAX_SECTIONS           = MAX_SEC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_word_t          in_word,
  input  logic [BPS_W-1:0]  bps,
  input  logic [SEC_W-1:0]  nsec,
  input  sbba_cmd_t         cmd,
  output sbba_sts_t         sts,
  output logic [BLK_W-1:0]  res_block,
  output logic [STAT_W-1:0] res_status
);

  localparam int SECTION_BYTES = (MAX_BLOCKS_PER_SECTION + 7) / 8;
  localparam int MAP_BYTES     = SECTION_BYTES * MAX_SECTIONS;
  localparam int ADDR_W        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  logic [7:0] mem [0:MAP_BYTES-1];
  logic [7:0] rdata_r;

  logic              req_r;
  logic [BLK_W-1:0]  blk_r;
  logic [BLK_W-1:0]  rem_r;
  logic [SEC_W-1:0]  hsec_r;
  logic [SEC_W-1:0]  cur_r;
  logic              first_r;
  logic [ADDR_W-1:0] sbase_r;
  logic [GOT_W-1:0]  bbase_r;
  logic [NB_W-1:0]   jn_r;
  logic [J_W-1:0]    jc_r;
  logic              chk_v_r;
  logic [GOT_W-1:0]  got_r;
  logic [STAT_W-1:0] stat_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [GOT_W-1:0]  limit;
  logic [ADDR_W-1:0] hint_addr;
  logic [7:0]        hint_mask;
  logic              hint_free;
  logic [NB_W-1:0]   nbytes;
  logic [7:0]        vmask;
  logic [7:0]        free_bits;
  logic [2:0]        low_k;
  logic              more;
  logic [ADDR_W-1:0] chk_addr;
  logic [ADDR_W-1:0] iss_addr;
  logic [CAND_W-1:0] cand0;
  logic [CAND_W-1:0] cand;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [ADDR_W-1:0] ra;
  logic [7:0]        wd;

  assign limit     = {{SEC_W{1'b0}}, bps} * {{BPS_W{1'b0}}, nsec};
  assign hint_addr = ADDR_W'(32'(sbase_r) + 32'(rem_r[BLK_W-1:3]));
  assign hint_mask = 8'd1 << rem_r[2:0];
  assign hint_free = (rdata_r & hint_mask) == 8'd0;

  assign nbytes    = NB_W'((12'(bps) + 12'd7) >> 3);
  assign vmask     = (jc_r < bps[BPS_W-1:3]) ? 8'hFF : ((8'd1 << bps[2:0]) - 8'd1);
  assign free_bits = ~rdata_r & vmask;
  assign more      = jn_r < nbytes;
  assign chk_addr  = ADDR_W'(32'(sbase_r) + 32'(jc_r));
  assign iss_addr  = ADDR_W'(32'(sbase_r) + 32'(jn_r));

  // lowest free bit of the checked byte
  always_comb begin
    low_k = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (free_bits[b]) low_k = 3'(b);
    end
  end

  // next section in ascending order, skipping the hint's section
  assign cand0 = first_r ? '0 : ({1'b0, cur_r} + CAND_W'(1));
  assign cand  = (cand0 == {1'b0, hsec_r}) ? (cand0 + CAND_W'(1)) : cand0;

  assign sts.clr_last   = clr_cnt_r == ADDR_W'(MAP_BYTES - 1);
  assign sts.in_range   = {{(GOT_W-BLK_W){1'b0}}, blk_r} < limit;
  assign sts.div_done   = rem_r < {{(BLK_W-BPS_W){1'b0}}, bps};
  assign sts.hint_taken = (req_r == REQ_FREE) || hint_free;
  assign sts.scan_hit   = chk_v_r && (free_bits != 8'd0);
  assign sts.sec_done   = !chk_v_r && !more;
  assign sts.no_sec     = cand >= {1'b0, nsec};

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = hint_addr;
    wd = rdata_r;
    if (cmd.clr) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = 8'd0;
    end else if (cmd.hint_upd) begin
      if (req_r == REQ_FREE) begin
        we = 1'b1;
        wd = rdata_r & ~hint_mask;
      end else if (hint_free) begin
        we = 1'b1;
        wd = rdata_r | hint_mask;
      end
    end else if (cmd.scan && sts.scan_hit) begin
      we = 1'b1;
      wa = chk_addr;
      wd = rdata_r | (8'd1 << low_k);
    end
  end

  assign ra = cmd.scan ? iss_addr : hint_addr;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      chk_v_r   <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (cmd.scan_init || cmd.next_sec) begin
        chk_v_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_v_r <= more;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_word.req_type;
      blk_r <= in_word.block_number;
    end
    if (cmd.set_range) begin
      got_r  <= '0;
      stat_r <= ST_RANGE;
    end
    if (cmd.set_full) begin
      got_r  <= '0;
      stat_r <= ST_FULL;
    end
    if (cmd.div_init) begin
      rem_r   <= blk_r;
      hsec_r  <= '0;
      sbase_r <= '0;
      bbase_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r   <= rem_r - {{(BLK_W-BPS_W){1'b0}}, bps};
      hsec_r  <= hsec_r + SEC_W'(1);
      sbase_r <= sbase_r + ADDR_W'(SECTION_BYTES);
      bbase_r <= bbase_r + {{SEC_W{1'b0}}, bps};
    end
    if (cmd.hint_upd && sts.hint_taken) begin
      got_r  <= {{(GOT_W-BLK_W){1'b0}}, blk_r};
      stat_r <= ST_DONE;
    end
    if (cmd.scan_init) begin
      cur_r   <= hsec_r;
      first_r <= 1'b1;
      jn_r    <= '0;
    end
    if (cmd.scan) begin
      if (sts.scan_hit) begin
        got_r  <= bbase_r + GOT_W'({jc_r, low_k});
        stat_r <= ST_DONE;
      end
      if (more) begin
        jc_r <= jn_r[J_W-1:0];
        jn_r <= jn_r + NB_W'(1);
      end
    end
    if (cmd.next_sec) begin
      cur_r   <= cand[SEC_W-1:0];
      first_r <= 1'b0;
      jn_r    <= '0;
      sbase_r <= ADDR_W'(32'(cand) * SECTION_BYTES);
      bbase_r <= GOT_W'({{BPS_W{1'b0}}, cand} * {{CAND_W{1'b0}}, bps});
    end
  end

  assign res_block  = got_r[BLK_W-1:0];
  assign res_status = stat_r;

endmodule

FILE: rtl/core/sbba_ctrl.sv
// Controller: state machine sequencing clear, lookup, scan and result hand-off.
module sbba_ctrl import sbba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  input  sbba_sts_t sts,
  output logic      in_stall,
  output sbba_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_HCHK = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_NEXT = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.in_range) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.set_range = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_HCHK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_HCHK: begin
        cmd.hint_upd = 1'b1;
        if (sts.hint_taken) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_nxt = S_FIN;
        end else if (sts.sec_done) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.no_sec) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.next_sec = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: verif/sbba_grant_checker.sv
`timescale 1ns / 100ps
// Grant checker: tracks the allocator's bitmap and geometry, predicts every answer and compares.
module sbba_grant_checker import sbba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    open_cnt,
  output int                    mismatches
);

  // Each section owns a fixed stretch of the bitmap, whatever its configured size.
  localparam int STRIDE = MAX_BPS_DEF;

  logic [MAX_SEC_DEF*STRIDE-1:0] used_map;
  logic [BPS_W-1:0]              bps_reg;
  logic [SEC_W-1:0]              nsec_reg;
  out_word_t                     grant_q[$];

  function automatic out_word_t serve_request(input in_word_t req);
    int unsigned bps, nsec, sec, idx, cur, s, i, got;
    logic        hit;
    out_word_t   ans;
    bps  = (bps_reg == 0) ? 1 : ((bps_reg > MAX_BPS_DEF) ? MAX_BPS_DEF : bps_reg);
    nsec = (nsec_reg == 0) ? 1 : ((nsec_reg > MAX_SEC_DEF) ? MAX_SEC_DEF : nsec_reg);
    ans.granted_block = '0;
    ans.status        = ST_DONE;
    if (req.block_number >= bps * nsec) begin
      ans.status = ST_RANGE;
      return ans;
    end
    sec = req.block_number / bps;
    idx = req.block_number % bps;
    if (req.req_type == REQ_FREE) begin
      used_map[sec*STRIDE + idx] = 1'b0;
      ans.granted_block = req.block_number;
      return ans;
    end
    if (!used_map[sec*STRIDE + idx]) begin
      used_map[sec*STRIDE + idx] = 1'b1;
      ans.granted_block = req.block_number;
      return ans;
    end
    // Hint taken: own section first, then the others in ascending order.
    hit = 1'b0;
    got = 0;
    for (s = 0; s <= nsec && !hit; s++) begin
      cur = (s == 0) ? sec : s - 1;
      if (s == 0 || cur != sec) begin
        for (i = 0; i < bps && !hit; i++) begin
          if (!used_map[cur*STRIDE + i]) begin
            used_map[cur*STRIDE + i] = 1'b1;
            got = cur * bps + i;
            hit = 1'b1;
          end
        end
      end
    end
    if (hit) ans.granted_block = got[BLK_W-1:0];
    else ans.status = ST_FULL;
    return ans;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      used_map   = '0;
      bps_reg    = BPS_RST;
      nsec_reg   = NSEC_RST;
      mismatches = 0;
      grant_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got block %0d status %0d",
                   $time, out_word.granted_block, out_word.status);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          if (out_word.granted_block !== want.granted_block) begin
            $display("%0t ns: granted_block expected %0d, got %0d",
                     $time, want.granted_block, out_word.granted_block);
            mismatches++;
          end
          if (out_word.status !== want.status) begin
            $display("%0t ns: status expected %0d, got %0d",
                     $time, want.status, out_word.status);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BPS:  bps_reg = cfg_data;
          CFG_NSEC: nsec_reg = cfg_data[SEC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) grant_q.push_back(serve_request(in_word));
    end
    open_cnt <= grant_q.size();
  end

endmodule

FILE: verif/sectioned_bitmap_block_allocator_top_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives requests and geometry writes into the allocator and reports the verdict.
module sectioned_bitmap_block_allocator_top_tb;
  import sbba_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int open_cnt;
  int mismatches;

  // Request words accepted so far; the receiver uses it to time its long hold.
  int unsigned sent_cnt = 0;

  sectioned_bitmap_block_allocator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbba_grant_checker grant_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .open_cnt   (open_cnt),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (full scans, stalls, the clearing pass).
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one request word and hold it until the allocator takes it.
  // Valid is left high so the next word can follow back to back.
  task automatic push_req(input logic op, input logic [BLK_W-1:0] blk);
    in_valid <= 1'b1;
    in_word  <= '{req_type: op, block_number: blk};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // Present one register word; the caller drops cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write both geometry registers, plus a stray word to an unused index that must be ignored.
  // Junk goes into the upper data bits of the section count too; only its low bits count.
  task automatic set_geometry(input logic [BPS_W-1:0] bps, input logic [SEC_W-1:0] nsec);
    logic [CFG_DATA_W-SEC_W-1:0] junk;
    junk = (CFG_DATA_W-SEC_W)'($urandom);
    write_reg(CFG_BPS, bps);
    write_reg(CFG_NSEC, {junk, nsec});
    write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait until every predicted answer has come back, then let the block settle.
  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Receiver: cycle through quiet, light, heavy and bursty stall modes. Once, after the
  // sender has moved a fair number of words, hold off for a long stretch so the output
  // register fills, the next word parks inside, and in_stall has to come up.
  initial begin
    int unsigned beat;
    bit          long_hold_done;
    beat           = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (!long_hold_done && sent_cnt >= 80) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        case ((beat / 97) % 4)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ((beat % 8) < 5);
        endcase
      end
    end
  end

  // Sender: directed corner cases first, then random phases under a range of geometries.
  initial begin
    int unsigned raw_bps [8];
    int unsigned raw_nsec[8];
    int unsigned eff_bps, eff_nsec, total, burst_left, gap, sel, base;
    logic [BLK_W-1:0] blk;
    logic             op;

    raw_bps  = '{1024, 3, 0, 1024, 5, 16, 2047, 7};
    raw_nsec = '{8, 3, 15, 1, 8, 2, 0, 5};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry, 8 x 1024: hint free, hint taken (scan own section), top block,
    // free then free again while already free, alternating bit patterns.
    push_req(REQ_ALLOC, '0);
    push_req(REQ_ALLOC, '0);
    push_req(REQ_ALLOC, 13'h1FFF);
    push_req(REQ_FREE,  13'h1FFF);
    push_req(REQ_FREE,  13'h1FFF);
    push_req(REQ_ALLOC, 13'h1555);
    push_req(REQ_ALLOC, 13'h0AAA);
    drain(4);

    // Two sections of two: out-of-range allocate and free; taken hints whose own section is
    // full, so the grant comes from the other section or the map reports full; free and allocate again.
    set_geometry(11'd2, 4'd2);
    push_req(REQ_ALLOC, 13'd0);
    push_req(REQ_ALLOC, 13'd4);
    push_req(REQ_FREE,  13'd7);
    push_req(REQ_FREE,  13'h1FFF);
    push_req(REQ_ALLOC, 13'd3);
    push_req(REQ_ALLOC, 13'd1);
    push_req(REQ_FREE,  13'd1);
    push_req(REQ_ALLOC, 13'd3);
    drain(4);

    // Zero in both registers acts as one: a single block that is already in use.
    set_geometry(11'd0, 4'd0);
    push_req(REQ_ALLOC, 13'd0);
    push_req(REQ_ALLOC, 13'd1);
    push_req(REQ_FREE,  13'd0);
    push_req(REQ_ALLOC, 13'd0);
    drain(4);

    // Oversized values clamp to the full 8 x 1024 map.
    set_geometry(11'd2047, 4'd15);
    push_req(REQ_ALLOC, 13'h1FFF);
    push_req(REQ_ALLOC, 13'd1024);
    drain(4);

    // Random phases: 65 words each in bursts with random gaps.
    burst_left = 0;
    for (int ph = 0; ph < 8; ph++) begin
      set_geometry(BPS_W'(raw_bps[ph]), SEC_W'(raw_nsec[ph]));
      eff_bps  = (raw_bps[ph] == 0) ? 1 : ((raw_bps[ph] > MAX_BPS_DEF) ? MAX_BPS_DEF : raw_bps[ph]);
      eff_nsec = (raw_nsec[ph] == 0) ? 1
                 : ((raw_nsec[ph] > MAX_SEC_DEF) ? MAX_SEC_DEF : raw_nsec[ph]);
      total    = eff_bps * eff_nsec;
      for (int n = 0; n < 65; n++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 12);
        end
        op  = ($urandom_range(0, 99) < 60) ? REQ_ALLOC : REQ_FREE;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          // anywhere in the 13-bit field
          blk = BLK_W'($urandom_range(0, 8191));
        end else if (sel == 1) begin
          // straddle the last valid block
          base = total - 1 + $urandom_range(0, 2);
          blk  = BLK_W'((base > 8191) ? 8191 : base);
        end else begin
          blk = BLK_W'($urandom_range(0, total - 1));
        end
        push_req(op, blk);
        burst_left--;
      end
      drain(4);
    end

    // Let anything stray surface before the verdict.
    drain(1200);
    if (mismatches == 0 && open_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
